// ===== src/crds_pkg.sv =====
package crds_pkg;

  // default number of code units held in the bitmaps
  localparam int CODE_UNITS_DEF = 256;

  // widest code unit index the block supports (65536 units)
  localparam int IDX_MAX_W = 16;

  // width that holds any unit count, used for range checks
  localparam int SPAN_W = 17;

  // operation codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_FETCH = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // one request
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] range_low;
    logic [7:0] range_high;
  } crds_in_t;

  // one returned piece
  typedef struct packed {
    logic       piece_valid;
    logic [7:0] piece_low;
    logic [7:0] piece_high;
    logic       last_piece;
  } crds_out_t;

  // what the piece finder reports to the top level
  typedef struct packed {
    logic                 found;
    logic                 more;
    logic [IDX_MAX_W-1:0] low;
    logic [IDX_MAX_W-1:0] high;
  } crds_find_t;

endpackage

// ===== src/crds_if.sv =====
// request channel
interface crds_in_if;
  import crds_pkg::*;

  logic     valid;
  logic     ready;
  crds_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// response channel
interface crds_out_if;
  import crds_pkg::*;

  logic      valid;
  logic      ready;
  crds_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/crds_piece_find.sv =====
module crds_piece_find #(
  parameter int CODE_UNITS = crds_pkg::CODE_UNITS_DEF
) (
  input  logic [CODE_UNITS-1:0]             covered,
  input  logic [CODE_UNITS-1:0]             cut,
  input  logic [$clog2(CODE_UNITS+1)-1:0]   scan,
  output crds_pkg::crds_find_t              find
);
  import crds_pkg::*;

  localparam int IDX_W  = $clog2(CODE_UNITS);
  localparam int SCAN_W = $clog2(CODE_UNITS + 1);
  localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(CODE_UNITS - 1);

  logic [CODE_UNITS-1:0] ones;
  logic [CODE_UNITS-1:0] avail;
  logic [CODE_UNITS-1:0] stop;
  logic                  start_found;
  logic [IDX_W-1:0]      start_idx;
  logic                  stop_found;
  logic [IDX_W-1:0]      stop_idx;
  logic [IDX_W-1:0]      end_idx;
  logic                  any_covered;
  logic [IDX_W-1:0]      top_covered;

  assign ones = '1;

  // covered units at or past the scan position
  assign avail = covered & (ones << scan);

  // lowest available unit starts the piece
  always_comb begin
    start_found = 1'b0;
    start_idx   = '0;
    for (int i = CODE_UNITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        start_found = 1'b1;
        start_idx   = IDX_W'(i);
      end
    end
  end

  // the piece ends before the next gap or cut above its start
  assign stop = (~covered | cut) & (ones << (SCAN_W'(start_idx) + 1'b1));

  always_comb begin
    stop_found = 1'b0;
    stop_idx   = '0;
    for (int i = CODE_UNITS - 1; i >= 0; i--) begin
      if (stop[i]) begin
        stop_found = 1'b1;
        stop_idx   = IDX_W'(i);
      end
    end
  end

  assign end_idx = stop_found ? (stop_idx - 1'b1) : TOP_IDX;

  // highest covered unit, for the last piece flag
  always_comb begin
    top_covered = '0;
    for (int i = 0; i < CODE_UNITS; i++) begin
      if (covered[i]) begin
        top_covered = IDX_W'(i);
      end
    end
  end

  assign any_covered = |covered;

  assign find.found = start_found;
  assign find.more  = any_covered && (top_covered > end_idx);
  assign find.low   = IDX_MAX_W'(start_idx);
  assign find.high  = IDX_MAX_W'(end_idx);

endmodule

// ===== src/char_range_disjoint_splitter_top.sv =====
// channel | role   | payload                                          | transfer
// req     | sink   | operation, range_low, range_high                 | valid & ready
// rsp     | source | piece_valid, piece_low, piece_high, last_piece   | valid & ready
//
// A request is registered on transfer and executed from there; a fetch puts its
// piece in the response register; one request per cycle is taken unless a fetch stalls.
// The path is set by the chain of two priority encoders over the bitmaps.
// Reset (rst, synchronous) empties both bitmaps and rewinds the scan.
// A stalled response holds a fetch in the request register and the requests
// behind it wait; adds and clears never wait on the response themselves.
module char_range_disjoint_splitter_top #(
  parameter int CODE_UNITS = crds_pkg::CODE_UNITS_DEF
) (
  input logic       clk,
  input logic       rst,
  crds_in_if.sink   req,
  crds_out_if.source rsp
);
  import crds_pkg::*;

  localparam int IDX_W  = $clog2(CODE_UNITS);
  localparam int SCAN_W = $clog2(CODE_UNITS + 1);
  localparam logic [IDX_W-1:0]  TOP_IDX = IDX_W'(CODE_UNITS - 1);
  localparam logic [SPAN_W-1:0] N_SPAN  = SPAN_W'(CODE_UNITS);

  // registers
  logic                  in_valid;
  crds_in_t              in_item;
  logic                  out_valid;
  crds_out_t             out_item;
  logic [CODE_UNITS-1:0] covered;
  logic [CODE_UNITS-1:0] cut;
  logic [SCAN_W-1:0]     scan;

  logic [CODE_UNITS-1:0] covered_next;
  logic [CODE_UNITS-1:0] cut_next;
  logic [SCAN_W-1:0]     scan_next;
  crds_out_t             out_item_next;

  logic                  out_free;
  logic                  is_fetch;
  logic                  advance;
  logic [SPAN_W-1:0]     lo_span;
  logic [SPAN_W-1:0]     hi_span;
  logic                  add_ok;
  logic [IDX_W-1:0]      lo_idx;
  logic [IDX_W-1:0]      hi_idx;
  logic [CODE_UNITS-1:0] ones;
  logic [CODE_UNITS-1:0] range_mask;
  crds_find_t            find;

  crds_piece_find #(
    .CODE_UNITS (CODE_UNITS)
  ) u_find (
    .covered (covered),
    .cut     (cut),
    .scan    (scan),
    .find    (find)
  );

  // handshake control
  assign out_free  = !out_valid || rsp.ready;
  assign is_fetch  = (in_item.operation == OP_FETCH);
  assign advance   = in_valid && (!is_fetch || out_free);
  assign req.ready = !in_valid || advance;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;

  // range decode for an add
  assign ones    = '1;
  assign lo_span = SPAN_W'(in_item.range_low);
  assign hi_span = SPAN_W'(in_item.range_high);
  assign add_ok  = (hi_span >= lo_span) && (lo_span < N_SPAN);
  assign lo_idx  = lo_span[IDX_W-1:0];
  assign hi_idx  = (hi_span >= N_SPAN) ? TOP_IDX : hi_span[IDX_W-1:0];
  assign range_mask = (ones << lo_idx) & (ones >> (TOP_IDX - hi_idx));

  // next store state and response
  always_comb begin
    covered_next  = covered;
    cut_next      = cut;
    scan_next     = scan;
    out_item_next = '0;
    case (in_item.operation)
      OP_ADD: begin
        if (add_ok) begin
          covered_next = covered | range_mask;
          cut_next[lo_idx] = 1'b1;
          if (hi_span < (N_SPAN - 1'b1)) begin
            cut_next[hi_idx + 1'b1] = 1'b1;
          end
          scan_next = '0;
        end
      end
      OP_FETCH: begin
        if (find.found) begin
          scan_next                = SCAN_W'(find.high[IDX_W-1:0]) + 1'b1;
          out_item_next.piece_valid = 1'b1;
          out_item_next.piece_low   = find.low[7:0];
          out_item_next.piece_high  = find.high[7:0];
          out_item_next.last_piece  = !find.more;
        end else begin
          covered_next = '0;
          cut_next     = '0;
          scan_next    = '0;
        end
      end
      OP_CLEAR: begin
        covered_next = '0;
        cut_next     = '0;
        scan_next    = '0;
      end
      default: begin
      end
    endcase
  end

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item <= req.data;
    end
  end

  // store update
  always_ff @(posedge clk) begin
    if (rst) begin
      covered <= '0;
      cut     <= '0;
      scan    <= '0;
    end else if (advance) begin
      covered <= covered_next;
      cut     <= cut_next;
      scan    <= scan_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && is_fetch) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_fetch) begin
      out_item <= out_item_next;
    end
  end

endmodule
